@@ src/salct_pkg.sv @@
package salct_pkg;

    localparam int MAX_ROWS  = 256;
    localparam int MAX_WAYS  = 8;
    localparam int ADDR_BITS = 13;
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int WAY_BITS  = $clog2(MAX_WAYS);
    localparam int TAG_BITS  = ADDR_BITS;
    localparam int AGE_BITS  = 3;
    localparam int CFG_BITS  = 4;
    localparam int IDX_BITS  = 2;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_BLOCK_SIZE_LOG2 = 2'd0,
        CFG_ROW_COUNT_LOG2  = 2'd1,
        CFG_WAYS_IN_USE     = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_SCAN,
        S_LIMIT,
        S_UPDT,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic                vld;
        logic [AGE_BITS-1:0] age;
        logic [TAG_BITS-1:0] tag;
    } t_way;

    typedef t_way [MAX_WAYS-1:0] t_line;

    localparam int LINE_BITS = $bits(t_line);

endpackage

@@ src/salct_ram.sv @@
module salct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/set_assoc_lru_cache_tags.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_word_address
// result    out        o_out_valid / i_out_stall o_hit, o_row_index, o_way_index
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each item passes through these states in order, W being the ways in
// use (1..8): S_READ splits the address and reads the row, S_LOAD loads it,
// S_SCAN walks the W ways with the single tag/age compare unit to find the
// way, S_LIMIT fetches the touched way's rank, S_UPDT re-ranks the W ways, and
// S_WRITE writes the row back. The next item is taken only once the block
// has written the previous one back and returned to S_IDLE.
// Reset (synchronous, active low) empties every row through one flag per row;
// the row memory itself is never swept.
// o_in_stall stays high while an item is in flight; a result held by
// i_out_stall blocks the write-back cycle until the output register frees up.
module set_assoc_lru_cache_tags (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [salct_pkg::ADDR_BITS-1:0]     i_word_address,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_hit,
    output logic [salct_pkg::ROW_BITS-1:0]      o_row_index,
    output logic [salct_pkg::WAY_BITS-1:0]      o_way_index,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [salct_pkg::IDX_BITS-1:0]      i_cfg_index,
    input  logic [salct_pkg::CFG_BITS-1:0]      i_cfg_data
);

    import salct_pkg::*;

    // control
    t_state                r_state, n_state;
    logic [MAX_ROWS-1:0]   r_row_vld, n_row_vld;
    logic                  r_out_vld, n_out_vld;
    logic [CFG_BITS-1:0]   r_blk_log2, n_blk_log2;
    logic [CFG_BITS-1:0]   r_row_log2, n_row_log2;
    logic [CFG_BITS-1:0]   r_ways, n_ways;

    // datapath
    logic [ADDR_BITS-1:0]  r_addr, n_addr;
    logic [ROW_BITS-1:0]   r_row, n_row;
    logic [TAG_BITS-1:0]   r_tag, n_tag;
    t_line                 r_line, n_line;
    logic [WAY_BITS-1:0]   r_k, n_k;
    logic                  r_hit, n_hit;
    logic [WAY_BITS-1:0]   r_way_hit, n_way_hit;
    logic                  r_emp, n_emp;
    logic [WAY_BITS-1:0]   r_way_emp, n_way_emp;
    logic [AGE_BITS-1:0]   r_best, n_best;
    logic [WAY_BITS-1:0]   r_way_vic, n_way_vic;
    logic [WAY_BITS-1:0]   r_way, n_way;
    logic [AGE_BITS:0]     r_limit, n_limit;
    logic                  r_o_hit, n_o_hit;
    logic [ROW_BITS-1:0]   r_o_row, n_o_row;
    logic [WAY_BITS-1:0]   r_o_way, n_o_way;

    // address split and config clamps
    logic [WAY_BITS:0]     ways_m1;
    logic [CFG_BITS-1:0]   row_shift;
    logic [ADDR_BITS-1:0]  blk;
    logic [ROW_BITS:0]     row_one;
    logic [ROW_BITS-1:0]   row_of_addr;
    logic [TAG_BITS-1:0]   tag_of_addr;
    logic                  last_k;

    // shared lane unit
    logic [WAY_BITS-1:0]   sel;
    t_way                  lane;
    t_way                  lane_upd;

    // row memory
    logic                  ram_we;
    logic [LINE_BITS-1:0]  ram_rdata;

    salct_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (r_line),
        .i_raddr (row_of_addr),
        .o_rdata (ram_rdata)
    );

    // Ways in use clamp to 1..MAX_WAYS; row bits clamp to the row index width.
    always_comb begin
        if (r_ways == '0) begin
            ways_m1 = '0;
        end else if (r_ways > CFG_BITS'(MAX_WAYS)) begin
            ways_m1 = (WAY_BITS+1)'(MAX_WAYS - 1);
        end else begin
            ways_m1 = (WAY_BITS+1)'(r_ways - 1'b1);
        end
        row_shift   = (r_row_log2 > CFG_BITS'(ROW_BITS)) ? CFG_BITS'(ROW_BITS) : r_row_log2;
        blk         = r_addr >> r_blk_log2;
        row_one     = (ROW_BITS+1)'(1) << row_shift;
        row_of_addr = ROW_BITS'(blk) & ROW_BITS'(row_one - 1'b1);
        tag_of_addr = blk >> row_shift;
        last_k      = ({1'b0, r_k} == ways_m1);
    end

    // One lane of the row register is looked at per cycle.
    always_comb begin
        sel  = (r_state == S_LIMIT) ? r_way : r_k;
        lane = r_line[sel];

        // re-rank: the touched way goes to the front, younger valid ways age
        lane_upd = lane;
        if (r_k == r_way) begin
            lane_upd.age = '0;
            if (!r_hit) begin
                lane_upd.vld = 1'b1;
                lane_upd.tag = r_tag;
            end
        end else if (lane.vld && ({1'b0, lane.age} < r_limit) && (lane.age != AGE_MAX)) begin
            lane_upd.age = lane.age + 1'b1;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state    = r_state;
        n_row_vld  = r_row_vld;
        n_out_vld  = r_out_vld;
        n_blk_log2 = r_blk_log2;
        n_row_log2 = r_row_log2;
        n_ways     = r_ways;
        n_addr     = r_addr;
        n_row      = r_row;
        n_tag      = r_tag;
        n_line     = r_line;
        n_k        = r_k;
        n_hit      = r_hit;
        n_way_hit  = r_way_hit;
        n_emp      = r_emp;
        n_way_emp  = r_way_emp;
        n_best     = r_best;
        n_way_vic  = r_way_vic;
        n_way      = r_way;
        n_limit    = r_limit;
        n_o_hit    = r_o_hit;
        n_o_row    = r_o_row;
        n_o_way    = r_o_way;
        ram_we     = 1'b0;
        o_in_stall = (r_state != S_IDLE);

        // drop the result once taken
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BLOCK_SIZE_LOG2: n_blk_log2 = i_cfg_data;
                CFG_ROW_COUNT_LOG2:  n_row_log2 = i_cfg_data;
                CFG_WAYS_IN_USE:     n_ways     = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_addr  = i_word_address;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // memory read address is the row of r_addr this cycle
                n_row   = row_of_addr;
                n_tag   = tag_of_addr;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_line = ram_rdata;
                if (!r_row_vld[r_row]) begin
                    for (int w = 0; w < MAX_WAYS; w++) begin
                        n_line[w].vld = 1'b0;
                        n_line[w].age = '0;
                    end
                end
                n_k     = '0;
                n_hit   = 1'b0;
                n_emp   = 1'b0;
                n_best  = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!r_hit && lane.vld && (lane.tag == r_tag)) begin
                    n_hit     = 1'b1;
                    n_way_hit = r_k;
                end
                if (!r_emp && !lane.vld) begin
                    n_emp     = 1'b1;
                    n_way_emp = r_k;
                end
                // oldest way, ties to the lowest way number
                if ((r_k == '0) || (lane.age > r_best)) begin
                    n_best    = lane.age;
                    n_way_vic = r_k;
                end
                if (last_k) begin
                    n_state = S_LIMIT;
                    if (n_hit) begin
                        n_way = n_way_hit;
                    end else if (n_emp) begin
                        n_way = n_way_emp;
                    end else begin
                        n_way = n_way_vic;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_LIMIT: begin
                // an empty way lets every valid way age
                n_limit = lane.vld ? {1'b0, lane.age} : {1'b0, AGE_MAX} + 1'b1;
                n_k     = '0;
                n_state = S_UPDT;
            end
            S_UPDT: begin
                n_line[r_k] = lane_upd;
                if (last_k) begin
                    n_state = S_WRITE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_WRITE: begin
                // hold the write-back until the output register is free
                if (!r_out_vld || !i_out_stall) begin
                    ram_we           = 1'b1;
                    n_row_vld[r_row] = 1'b1;
                    n_out_vld        = 1'b1;
                    n_o_hit          = r_hit;
                    n_o_row          = r_row;
                    n_o_way          = r_way;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_row_vld  <= '0;
            r_out_vld  <= 1'b0;
            r_blk_log2 <= '0;
            r_row_log2 <= '0;
            r_ways     <= CFG_BITS'(1);
        end else begin
            r_state    <= n_state;
            r_row_vld  <= n_row_vld;
            r_out_vld  <= n_out_vld;
            r_blk_log2 <= n_blk_log2;
            r_row_log2 <= n_row_log2;
            r_ways     <= n_ways;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_row     <= n_row;
        r_tag     <= n_tag;
        r_line    <= n_line;
        r_k       <= n_k;
        r_hit     <= n_hit;
        r_way_hit <= n_way_hit;
        r_emp     <= n_emp;
        r_way_emp <= n_way_emp;
        r_best    <= n_best;
        r_way_vic <= n_way_vic;
        r_way     <= n_way;
        r_limit   <= n_limit;
        r_o_hit   <= n_o_hit;
        r_o_row   <= n_o_row;
        r_o_way   <= n_o_way;
    end

    assign o_out_valid = r_out_vld;
    assign o_hit       = r_o_hit;
    assign o_row_index = r_o_row;
    assign o_way_index = r_o_way;

    a_result_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_WRITE))
        else $error("result raised outside the write-back cycle");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_UPDT) |-> ({1'b0, r_k} <= ways_m1))
        else $error("way cursor past the ways in use");

    a_touched_way_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_line[r_way].vld && (r_line[r_way].age == '0)))
        else $error("touched way not valid and most recent at write-back");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && (r_state == S_READ)))
        else $error("accepted item did not start a lookup");

    a_result_way_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ({1'b0, o_way_index} <= ways_m1))
        else $error("reported way outside the ways in use");

endmodule

@@ sim/set_assoc_lru_cache_tags_test.sv @@
module set_assoc_lru_cache_tags_test;

    timeunit 1ns;
    timeprecision 1ps;

    import salct_pkg::*;

    // Cycles to let pass after the last result before touching the registers
    // or ending the run.
    localparam int SETTLE_CYCLES = 32;
    // Receiver hold-off long enough to back the block up into its input.
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_COUNT = 10;
    localparam int PHASE_ITEMS = 85;
    // Index one past the register list; writes to it must be ignored.
    localparam logic [IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic                hit;
        logic [ROW_BITS-1:0] row;
        logic [WAY_BITS-1:0] way;
    } t_cache_lookup;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [ADDR_BITS-1:0] i_word_address = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_hit;
    logic [ROW_BITS-1:0]  o_row_index;
    logic [WAY_BITS-1:0]  o_way_index;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_BITS-1:0]  i_cfg_data = '0;

    // Shadow of the tag array: tags, valid bits and LRU ranks per row and way.
    logic [TAG_BITS-1:0] tag_mem [MAX_ROWS*MAX_WAYS];
    bit                  vld_mem [MAX_ROWS*MAX_WAYS];
    bit [AGE_BITS-1:0]   age_mem [MAX_ROWS*MAX_WAYS];

    // Shadow of the configuration registers, at their reset values.
    logic [CFG_BITS-1:0] cfg_blk = '0;
    logic [CFG_BITS-1:0] cfg_rows = '0;
    logic [CFG_BITS-1:0] cfg_ways = 4'd1;

    logic [ADDR_BITS-1:0] pending_addr_q [$];
    t_cache_lookup        outcome_q [$];
    t_cache_lookup        want;
    int unsigned          mismatch_cnt = 0;

    logic        in_fire = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          pat_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    set_assoc_lru_cache_tags i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Clamp the row count to what the row index can address.
    function automatic int eff_row_log2();
        return (cfg_rows > ROW_BITS) ? ROW_BITS : int'(cfg_rows);
    endfunction

    // Zero ways behaves as one, anything past the array width as all ways.
    function automatic int eff_ways();
        if (cfg_ways == 0)
            return 1;
        return (cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways);
    endfunction

    // Look one address up in the shadow array and update it as the block does:
    // hit, else first empty way, else least recently used (lowest way on ties).
    function automatic t_cache_lookup cache_lookup(input logic [ADDR_BITS-1:0] addr);
        int                   rl;
        int                   ways;
        int                   row;
        int                   base;
        int                   way;
        int                   lim;
        bit                   hit;
        bit                   found;
        logic [ADDR_BITS-1:0] blk_num;
        logic [TAG_BITS-1:0]  tag;
        t_cache_lookup        res;
        rl      = eff_row_log2();
        ways    = eff_ways();
        blk_num = addr >> cfg_blk;
        row     = int'(blk_num) & ((1 << rl) - 1);
        tag     = blk_num >> rl;
        base    = row * MAX_WAYS;
        hit     = 0;
        found   = 0;
        way     = 0;
        for (int k = 0; k < ways && !hit; k++) begin
            if (vld_mem[base+k] && tag_mem[base+k] == tag) begin
                hit = 1;
                way = k;
            end
        end
        if (!hit) begin
            for (int k = 0; k < ways && !found; k++) begin
                if (!vld_mem[base+k]) begin
                    found = 1;
                    way   = k;
                end
            end
            if (!found) begin
                for (int k = 1; k < ways; k++) begin
                    if (age_mem[base+k] > age_mem[base+way])
                        way = k;
                end
            end
        end
        // Age every valid way that was more recent than the touched one;
        // an empty way counts as older than any rank.
        lim = vld_mem[base+way] ? int'(age_mem[base+way]) : int'(AGE_MAX) + 1;
        for (int k = 0; k < ways; k++) begin
            if (k != way && vld_mem[base+k] && age_mem[base+k] < lim
                    && age_mem[base+k] != AGE_MAX)
                age_mem[base+k] = age_mem[base+k] + 1'b1;
        end
        age_mem[base+way] = '0;
        if (!hit) begin
            tag_mem[base+way] = tag;
            vld_mem[base+way] = 1'b1;
        end
        res.hit = hit;
        res.row = row[ROW_BITS-1:0];
        res.way = way[WAY_BITS-1:0];
        return res;
    endfunction

    // Build an address from tag, row and word offset under the current setup.
    function automatic logic [ADDR_BITS-1:0] pack_address(input int unsigned tag,
                                                          input int unsigned row,
                                                          input int unsigned off);
        int unsigned a;
        a = (tag << (cfg_blk + eff_row_log2())) | (row << cfg_blk)
            | (off & ((1 << cfg_blk) - 1));
        return a[ADDR_BITS-1:0];
    endfunction

    // Write one register and track it in the shadow copy.
    task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_BLOCK_SIZE_LOG2: cfg_blk  = val;
            CFG_ROW_COUNT_LOG2:  cfg_rows = val;
            CFG_WAYS_IN_USE:     cfg_ways = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_cache(input logic [CFG_BITS-1:0] blk,
                                 input logic [CFG_BITS-1:0] rows,
                                 input logic [CFG_BITS-1:0] ways);
        write_reg(CFG_BLOCK_SIZE_LOG2, blk);
        write_reg(CFG_ROW_COUNT_LOG2, rows);
        write_reg(CFG_WAYS_IN_USE, ways);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_SPARE, CFG_BITS'($urandom));
    endtask

    // Hold until every queued access went in and every lookup came back,
    // then let the block settle.
    task automatic wait_until_quiet();
        do @(posedge i_clk);
        while (pending_addr_q.size() != 0 || i_in_valid || outcome_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Queue a mix of accesses: mostly reuse of a few tags crowded into a few
    // rows (at least as many tags as ways, so hits, fills and LRU evictions all occur),
    // plus fully random addresses and fresh tags in the crowded rows.
    task automatic queue_accesses(input int count);
        int                   rl;
        int                   n_rows;
        int                   n_tags;
        int                   pick;
        int unsigned          blk_mask;
        int unsigned          hot_row [$];
        logic [ADDR_BITS-1:0] hot_addr [$];
        logic [ADDR_BITS-1:0] a;
        rl       = eff_row_log2();
        blk_mask = (1 << cfg_blk) - 1;
        n_rows   = $urandom_range(1, 3);
        n_tags   = eff_ways() + $urandom_range(0, 3);
        for (int r = 0; r < n_rows; r++) begin
            hot_row.insert(hot_row.size(), $urandom & ((1 << rl) - 1));
            for (int t = 0; t < n_tags; t++)
                hot_addr.insert(hot_addr.size(),
                                pack_address($urandom, hot_row[r], $urandom));
        end
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                a = hot_addr[$urandom_range(0, hot_addr.size() - 1)];
                a = ADDR_BITS'((a & ~blk_mask) | ($urandom & blk_mask));
            end else if (pick < 9) begin
                a = ADDR_BITS'($urandom);
            end else begin
                a = pack_address($urandom, hot_row[$urandom_range(0, n_rows - 1)],
                                 $urandom);
            end
            pending_addr_q.insert(pending_addr_q.size(), a);
        end
    endtask

    // Note acceptance at the edge and predict the lookup right away.
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && o_in_stall === 1'b0;
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0)
            outcome_q.insert(outcome_q.size(), cache_lookup(i_word_address));
    end

    // Sender: offer queued addresses in bursts with random gaps in between.
    // Hold an offered item unchanged until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            // hold
        end else if (gap_left > 0) begin
            i_in_valid <= 1'b0;
            gap_left   <= gap_left - 1;
        end else if (pending_addr_q.size() > 0) begin
            i_in_valid     <= 1'b1;
            i_word_address <= pending_addr_q.pop_front();
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver: stall on a pattern that changes at random intervals, and
    // on request hold off for a long stretch so the block backs up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= LONG_HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (pat_left == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                pat_left   <= $urandom_range(16, 96);
            end else begin
                pat_left <= pat_left - 1;
            end
            case (stall_mode)
                STALL_NONE:   i_out_stall <= 1'b0;
                STALL_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // Compare each taken result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result: hit %0b row %0d way %0d",
                       o_hit, o_row_index, o_way_index);
                mismatch_cnt++;
            end else begin
                want = outcome_q.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0b, got %0b", want.hit, o_hit);
                    mismatch_cnt++;
                end
                if (o_row_index !== want.row) begin
                    $error("row_index: expected %0d, got %0d", want.row, o_row_index);
                    mismatch_cnt++;
                end
                if (o_way_index !== want.way) begin
                    $error("way_index: expected %0d, got %0d", want.way, o_way_index);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [CFG_BITS-1:0] blk;
        logic [CFG_BITS-1:0] rows;
        logic [CFG_BITS-1:0] ways;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Direct-mapped, one word per block, one row: fill, replace, hit.
        program_cache(4'd0, 4'd0, 4'd1);
        pending_addr_q = '{13'h0000, 13'h1FFF, 13'h1FFF, 13'h0000};
        wait_until_quiet();

        // Four ways, two rows, two-word blocks: fill row 0 with tags 1..4,
        // touch tag 2, then bring in tags 5 and 1 to evict by LRU rank.
        program_cache(4'd1, 4'd1, 4'd4);
        for (int t = 1; t <= 4; t++)
            pending_addr_q.insert(pending_addr_q.size(), pack_address(t, 0, t));
        pending_addr_q.insert(pending_addr_q.size(), pack_address(2, 0, 0));
        pending_addr_q.insert(pending_addr_q.size(), pack_address(5, 0, 1));
        pending_addr_q.insert(pending_addr_q.size(), pack_address(1, 0, 0));
        pending_addr_q.insert(pending_addr_q.size(), 13'h1FFF);
        wait_until_quiet();

        // Out-of-range settings: zero ways, too many rows, block wider than
        // the address; also a write past the register list, which is dropped.
        program_cache(4'd15, 4'd12, 4'd0);
        write_reg(CFG_IDX_SPARE, 4'hF);
        pending_addr_q = '{13'h1FFF, 13'h0000, 13'h1000};
        wait_until_quiet();

        // Too many ways, all rows, block just past the address width.
        program_cache(4'd14, 4'd8, 4'd15);
        pending_addr_q = '{13'h1FFF, 13'h0001};
        wait_until_quiet();

        // Random phases, contents kept across setting changes so ranks may tie.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin blk = 4'd0;  rows = 4'd0;  ways = 4'd1;  end
                1: begin blk = 4'd13; rows = 4'd8;  ways = 4'd8;  end
                2: begin blk = 4'd15; rows = 4'd15; ways = 4'd15; end
                3: begin blk = 4'd2;  rows = 4'd4;  ways = 4'd8;  end
                default: begin
                    blk  = CFG_BITS'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 4)
                                                                 : $urandom_range(0, 15));
                    rows = CFG_BITS'($urandom_range(0, 15));
                    ways = CFG_BITS'($urandom_range(0, 15));
                end
            endcase
            program_cache(blk, rows, ways);
            queue_accesses(PHASE_ITEMS);
            if (p == 4 || p == 8)
                hold_req++;
            wait_until_quiet();
        end

        if (outcome_q.size() != 0) begin
            $error("%0d results never arrived", outcome_q.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
